// File: rtl/core/lsa_pkg.sv
// Shared types and constants for the liveness slot allocator.
// No dependencies; used by every module under rtl/core.
package lsa_pkg;

    localparam int NUM_VARS_DEF = 4096;
    localparam int SLOT_W       = 12;
    localparam int INDEX_W      = 12;
    localparam int COUNT_W      = 13;
    localparam int OPCODE_W     = 2;
    localparam int STATUS_W     = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [OPCODE_W-1:0] OP_COUNT   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_ALLOC   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0] operation;
        logic [INDEX_W-1:0]  var_index;
        logic [INDEX_W-1:0]  op_index;
        logic                is_dep_op;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [INDEX_W-1:0]  op_echo;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic clr_en;
        logic capture;
        logic rd_en;
        logic ex_en;
    } lsa_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic rsp_blocked;
    } lsa_stat_t;

endpackage

// File: rtl/core/lsa_ctrl.sv
// Sequencing FSM for the slot allocator: clear pass, accept, read, execute.
// Depends on lsa_pkg.
module lsa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  lsa_pkg::lsa_stat_t  stat,
    output lsa_pkg::lsa_cmd_t   cmd
);

    localparam logic [1:0] S_CLR  = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_EX   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        case (state_reg)
            S_CLR:
            begin
                cmd.clr_en = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_EX;
            end
            S_EX:
            begin
                // hold until the result register can take the new result
                if (!stat.rsp_blocked)
                begin
                    cmd.ex_en  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/lsa_dpath.sv
// Datapath of the slot allocator: count, slot and free-stack memories,
// stack and fresh-slot counters, result register. Depends on lsa_pkg.
module lsa_dpath #(
    parameter int NUM_VARS = lsa_pkg::NUM_VARS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lsa_pkg::req_t       req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output lsa_pkg::rsp_t       rsp,
    input  lsa_pkg::lsa_cmd_t   cmd,
    output lsa_pkg::lsa_stat_t  stat
);

    localparam int IDX_W = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam int CNT_W = $clog2(NUM_VARS + 1);
    localparam logic [31:0] NV32 = 32'(NUM_VARS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VARS - 1);

    // memories
    logic [lsa_pkg::COUNT_W-1:0] cnt_mem [NUM_VARS];
    logic [lsa_pkg::SLOT_W-1:0]  sov_mem [NUM_VARS];
    logic [lsa_pkg::SLOT_W-1:0]  stk_mem [NUM_VARS];

    // captured request
    lsa_pkg::req_t req_reg;

    // registered read data
    logic [lsa_pkg::COUNT_W-1:0] cnt_rd_reg;
    logic [lsa_pkg::SLOT_W-1:0]  sov_rd_reg;
    logic [lsa_pkg::SLOT_W-1:0]  stk_rd_reg;

    logic [IDX_W-1:0] clr_idx_reg;
    logic [IDX_W-1:0] clr_idx_next;
    logic [CNT_W-1:0] free_top_reg;
    logic [CNT_W-1:0] free_top_next;
    logic [CNT_W-1:0] fresh_reg;
    logic [CNT_W-1:0] fresh_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    lsa_pkg::rsp_t    rsp_reg;
    lsa_pkg::rsp_t    rsp_next;

    logic [31:0]      var32;
    logic [31:0]      opi32;
    logic [31:0]      top32;
    logic [31:0]      fresh32;
    logic [IDX_W-1:0] var_addr;
    logic [IDX_W-1:0] opi_addr;
    logic [IDX_W-1:0] top_addr;
    logic [IDX_W-1:0] pop_addr;
    logic             var_ok;
    logic             opi_ok;

    // execute-stage write controls
    logic                        cnt_we;
    logic [IDX_W-1:0]            cnt_wa;
    logic [lsa_pkg::COUNT_W-1:0] cnt_wd;
    logic                        sov_we;
    logic                        stk_we;
    logic [lsa_pkg::SLOT_W-1:0]  slot_sel;

    assign var32    = 32'(req_reg.var_index);
    assign opi32    = 32'(req_reg.op_index);
    assign top32    = 32'(free_top_reg);
    assign fresh32  = 32'(fresh_reg);
    assign var_addr = var32[IDX_W-1:0];
    assign opi_addr = opi32[IDX_W-1:0];
    assign top_addr = top32[IDX_W-1:0];
    assign pop_addr = IDX_W'(free_top_reg - CNT_W'(1));
    assign var_ok   = (var32 < NV32);
    assign opi_ok   = (opi32 < NV32);

    assign stat.clr_last    = (clr_idx_reg == LAST_IDX);
    assign stat.rsp_blocked = rsp_valid_reg && rsp_stall;
    assign rsp_valid        = rsp_valid_reg;
    assign rsp              = rsp_reg;

    always_comb
    begin
        clr_idx_next   = clr_idx_reg;
        free_top_next  = free_top_reg;
        fresh_next     = fresh_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        cnt_we         = 1'b0;
        cnt_wa         = var_addr;
        cnt_wd         = '0;
        sov_we         = 1'b0;
        stk_we         = 1'b0;
        slot_sel       = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cmd.clr_en)
        begin
            cnt_we       = 1'b1;
            cnt_wa       = clr_idx_reg;
            clr_idx_next = clr_idx_reg + IDX_W'(1);
        end

        if (cmd.ex_en)
        begin
            rsp_next       = '0;
            rsp_valid_next = 1'b1;
            case (req_reg.operation)
                lsa_pkg::OP_COUNT:
                begin
                    if (var_ok)
                    begin
                        if (cnt_rd_reg == lsa_pkg::COUNT_MAX)
                        begin
                            rsp_next.status = lsa_pkg::ST_SATURATED;
                        end
                        else
                        begin
                            cnt_we = 1'b1;
                            cnt_wd = cnt_rd_reg + lsa_pkg::COUNT_W'(1);
                        end
                    end
                end
                lsa_pkg::OP_RELEASE:
                begin
                    if (var_ok)
                    begin
                        if (cnt_rd_reg == '0)
                        begin
                            rsp_next.status = lsa_pkg::ST_ZERO;
                        end
                        else
                        begin
                            cnt_we = 1'b1;
                            cnt_wd = cnt_rd_reg - lsa_pkg::COUNT_W'(1);
                            if (cnt_rd_reg == lsa_pkg::COUNT_W'(1))
                            begin
                                if (top32 < NV32)
                                begin
                                    stk_we        = 1'b1;
                                    free_top_next = free_top_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    rsp_next.status = lsa_pkg::ST_EXHAUSTED;
                                end
                            end
                        end
                    end
                end
                lsa_pkg::OP_ALLOC:
                begin
                    rsp_next.op_echo = req_reg.op_index;
                    if (!req_reg.is_dep_op && (free_top_reg != '0))
                    begin
                        free_top_next = free_top_reg - CNT_W'(1);
                        slot_sel      = stk_rd_reg;
                        sov_we        = opi_ok;
                    end
                    else if (fresh32 < NV32)
                    begin
                        fresh_next = fresh_reg + CNT_W'(1);
                        slot_sel   = fresh32[lsa_pkg::SLOT_W-1:0];
                        sov_we     = opi_ok;
                    end
                    else
                    begin
                        rsp_next.status = lsa_pkg::ST_EXHAUSTED;
                    end
                    rsp_next.slot = slot_sel;
                end
                default:
                begin
                    rsp_next = '0;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg   <= '0;
            free_top_reg  <= '0;
            fresh_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            clr_idx_reg   <= clr_idx_next;
            free_top_reg  <= free_top_next;
            fresh_reg     <= fresh_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (cmd.capture)
        begin
            req_reg <= req;
        end
    end

    // use counts: one write, one read
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (cmd.rd_en)
        begin
            cnt_rd_reg <= cnt_mem[var_addr];
        end
    end

    // slot of each variable
    always_ff @(posedge clk)
    begin
        if (sov_we)
        begin
            sov_mem[opi_addr] <= slot_sel;
        end
        if (cmd.rd_en)
        begin
            sov_rd_reg <= sov_mem[var_addr];
        end
    end

    // free-slot stack
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[top_addr] <= sov_rd_reg;
        end
        if (cmd.rd_en)
        begin
            stk_rd_reg <= stk_mem[pop_addr];
        end
    end

endmodule

// File: rtl/core/liveness_slot_allocator.sv
// Top level of the liveness slot allocator.
// Depends on lsa_pkg, lsa_ctrl and lsa_dpath.
//
// Request channel (req_valid / req_stall / req): operation, var_index,
// op_index, is_dep_op. count_use bumps a variable's use count, release_use
// drops it and frees the variable's slot when it reaches zero, allocate hands
// the op a slot (free stack first for ordinary ops, always a fresh slot for
// dependent-variable ops).
// Response channel (rsp_valid / rsp_stall / rsp): exactly one response per
// request, in order, with slot, op_echo and status.
// Timing: a request is taken in the idle state, the memories are read into
// registers in the read state, the result is written in the execute state,
// which holds while the response register is blocked. No new request is taken
// until the current one has left the execute state; req_stall is high till then.
// Reset: counters and the stack pointer clear at once; the use-count memory is
// then swept to zero, one entry per cycle, with req_stall held high.
// Backpressure: the response sits in an output register and holds while
// rsp_stall is high; the next request is still accepted and read, and its
// result waits until the register frees up.
module liveness_slot_allocator #(
    parameter int NUM_VARS = lsa_pkg::NUM_VARS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  lsa_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output lsa_pkg::rsp_t  rsp
);

    lsa_pkg::lsa_cmd_t  cmd;
    lsa_pkg::lsa_stat_t stat;

    // sequencing: clear sweep, accept, read, execute
    lsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // memories, counters and the response register
    lsa_dpath #(
        .NUM_VARS (NUM_VARS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
